// ===== rtl/som_pkg.sv =====
// Shared types, constants and helper functions for the SOM best matching unit search.
package som_pkg;

  // Map and vector limits
  localparam int MAX_MAP_X   = 16;
  localparam int MAX_MAP_Y   = 16;
  localparam int MAX_DIMS    = 256;
  localparam int NODE_COUNT  = MAX_MAP_X * MAX_MAP_Y;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int CNT_W       = NODE_W + 1;
  localparam int WADDR_W     = $clog2(NODE_COUNT * MAX_DIMS);

  // Field widths
  localparam int COORD_W     = 4;
  localparam int DIM_W       = 8;
  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int NORM_W      = 40;
  localparam int DIST_W      = 40;
  localparam int ACC_W       = 42;
  localparam int SIZE_W      = 5;
  localparam int DIMS_W      = 9;

  // Configuration port
  localparam int NUM_REGS    = 3;
  localparam int PADDR_W     = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W   = PADDR_W - 2;
  localparam int PDATA_W     = 32;
  localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_DIMS_IN_USE = REG_IDX_W'(2);

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Largest reportable distance
  localparam logic signed [ACC_W-1:0] DIST_MAX =
    {{(ACC_W - DIST_W){1'b0}}, {DIST_W{1'b1}}};

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_ENTRY = 1'b1
  } req_type_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SWEEP = 1'b1
  } cmd_op_e;

  typedef struct packed {
    req_type_e                   req_type;
    logic [COORD_W-1:0]          node_x;
    logic [COORD_W-1:0]          node_y;
    logic [DIM_W-1:0]            dim_index;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] best_x;
    logic [COORD_W-1:0] best_y;
    logic [DIST_W-1:0]  best_sq_distance;
  } out_item_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [SIZE_W-1:0] map_w;
    logic [SIZE_W-1:0] map_h;
    logic [DIMS_W-1:0] dims;
  } cfg_t;

  // Work handed from the front to the back
  typedef struct packed {
    cmd_op_e                    op;
    logic                       seed;
    logic                       apply;
    logic                       last;
    logic [NODE_W-1:0]          node;
    logic [DIM_W-1:0]           dim;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } queue_sts_t;

  typedef struct packed {
    logic vec_open;
  } front_sts_t;

  // Saturate a map size into 1..hi
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (int'(v) > hi) r = SIZE_W'(hi);
    return r;
  endfunction

  // Saturate the dimension count into 1..MAX_DIMS
  function automatic logic [DIMS_W-1:0] clamp_dims(logic [DIMS_W-1:0] v);
    logic [DIMS_W-1:0] r;
    r = v;
    if (v == '0) r = DIMS_W'(1);
    else if (int'(v) > MAX_DIMS) r = DIMS_W'(MAX_DIMS);
    return r;
  endfunction

endpackage

// ===== rtl/som_queue.sv =====
// Two-entry command queue between the front and the back.
module som_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  som_pkg::cmd_t       data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output som_pkg::cmd_t       data_o,
  output som_pkg::queue_sts_t sts_o
);

  som_pkg::cmd_t                   mem_q [som_pkg::QUEUE_DEPTH];
  logic [som_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [som_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [som_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                            do_push, do_pop;

  assign sts_o.full  = (count_q == som_pkg::QCNT_W'(som_pkg::QUEUE_DEPTH));
  assign sts_o.count = count_q;
  assign valid_o     = (count_q != '0);
  assign data_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && !sts_o.full;
  assign do_pop      = pop_i && valid_o;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == som_pkg::QPTR_W'(som_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == som_pkg::QPTR_W'(som_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== rtl/som_front.sv =====
// Front end: accepts items, tracks vector order and queues the work that matters.
module som_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  som_pkg::in_item_t   in_data_i,
  input  som_pkg::cfg_t       cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output som_pkg::cmd_t       q_data_o,
  output som_pkg::front_sts_t sts_o
);

  logic                      open_q, open_d;
  logic                      prev_vld_q, prev_vld_d;
  logic [som_pkg::DIM_W-1:0] prev_dim_q, prev_dim_d;
  logic                      fire, dim_ok, wr_ok, prev_live, apply, seed, needed;

  assign in_ready_o   = !q_full_i;
  assign fire         = in_valid_i && in_ready_o;
  assign sts_o.vec_open = open_q;

  // Classify the item
  always_comb begin
    dim_ok    = (som_pkg::DIMS_W'(in_data_i.dim_index) < cfg_i.dims);
    wr_ok     = (int'(in_data_i.node_x) < som_pkg::MAX_MAP_X) &&
                (int'(in_data_i.node_y) < som_pkg::MAX_MAP_Y) && dim_ok;
    prev_live = open_q && prev_vld_q;
    seed      = !open_q;
    apply     = dim_ok && (!prev_live || (in_data_i.dim_index > prev_dim_q));

    q_data_o.op     = (in_data_i.req_type == som_pkg::REQ_ENTRY) ? som_pkg::CMD_SWEEP
                                                                 : som_pkg::CMD_WRITE;
    q_data_o.seed   = seed;
    q_data_o.apply  = apply;
    q_data_o.last   = in_data_i.last;
    q_data_o.node   = som_pkg::NODE_W'(in_data_i.node_y) *
                      som_pkg::NODE_W'(som_pkg::MAX_MAP_X) +
                      som_pkg::NODE_W'(in_data_i.node_x);
    q_data_o.dim    = in_data_i.dim_index;
    q_data_o.sample = in_data_i.sample;

    if (in_data_i.req_type == som_pkg::REQ_ENTRY) needed = seed || apply || in_data_i.last;
    else needed = wr_ok;

    open_d     = open_q;
    prev_vld_d = prev_vld_q;
    prev_dim_d = prev_dim_q;
    if (fire && (in_data_i.req_type == som_pkg::REQ_ENTRY)) begin
      open_d     = !in_data_i.last;
      prev_vld_d = in_data_i.last ? 1'b0 : (apply || prev_live);
      if (apply) prev_dim_d = in_data_i.dim_index;
    end
  end

  assign q_push_o = fire && needed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      prev_vld_q <= 1'b0;
      prev_dim_q <= '0;
    end else begin
      open_q     <= open_d;
      prev_vld_q <= prev_vld_d;
      prev_dim_q <= prev_dim_d;
    end
  end

endmodule

// ===== rtl/som_back.sv =====
// Back end: codebook and norm updates, node sweep with accumulation and minimum search.
module som_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  som_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  som_pkg::cmd_t      q_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output som_pkg::out_item_t out_data_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_WR_RD  = 8'b00000010,
    S_WR_MUL = 8'b00000100,
    S_WR_UPD = 8'b00001000,
    S_SWEEP  = 8'b00010000,
    S_DRAIN  = 8'b00100000,
    S_HOLD   = 8'b01000000,
    S_CLEAR  = 8'b10000000
  } state_e;

  state_e                             state_q, state_d;
  logic [som_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [som_pkg::WADDR_W-1:0]        clr_q;
  som_pkg::cmd_t                      cmd_q;
  logic signed [som_pkg::SQ_W-1:0]    vv_q;

  // Memories
  logic signed [som_pkg::SAMPLE_W-1:0] wmem [som_pkg::NODE_COUNT * som_pkg::MAX_DIMS];
  logic signed [som_pkg::ACC_W-1:0]    acc_mem [som_pkg::NODE_COUNT];
  logic [som_pkg::NORM_W-1:0]          norm_mem [som_pkg::NODE_COUNT];
  logic [som_pkg::NODE_COUNT-1:0]      norm_vld_q;
  logic signed [som_pkg::SAMPLE_W-1:0] w_rdata_q;
  logic signed [som_pkg::ACC_W-1:0]    acc_rdata_q;
  logic [som_pkg::NORM_W-1:0]          norm_rdata_q;
  logic [som_pkg::NODE_W-1:0]          rd_node;
  logic [som_pkg::WADDR_W-1:0]         w_raddr, w_waddr;
  logic                                wr_commit;

  // Sweep pipeline
  logic                                s1_vld_q, s2_vld_q;
  logic [som_pkg::NODE_W-1:0]          s1_node_q, s2_node_q;
  logic signed [som_pkg::ACC_W-1:0]    s1_base, s2_base_q;
  logic signed [som_pkg::SQ_W-1:0]     s2_prod_q;
  logic signed [som_pkg::ACC_W-1:0]    term, acc_new;
  logic [som_pkg::COORD_W-1:0]         s2_x, s2_y;
  logic                                in_map;

  // Codebook write path
  logic signed [som_pkg::SQ_W-1:0]     ww_prod;
  logic [som_pkg::SQ_W-1:0]            oo_q;
  logic [som_pkg::NORM_W-1:0]          nbase_q, norm_new;

  // Minimum search and output
  logic                                found_q;
  logic signed [som_pkg::ACC_W-1:0]    best_q;
  logic [som_pkg::COORD_W-1:0]         bx_q, by_q;
  logic [som_pkg::DIST_W-1:0]          best_sat;
  logic                                out_vld_q, load_out;
  som_pkg::out_item_t                  out_q;

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign load_out    = (state_q == S_HOLD) && (!out_vld_q || out_ready_i);
  assign wr_commit   = (state_q == S_WR_UPD);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        cnt_d = '0;
        if (q_valid_i) begin
          state_d = (q_data_i.op == som_pkg::CMD_WRITE) ? S_WR_RD : S_SWEEP;
        end
      end
      S_WR_RD:  state_d = S_WR_MUL;
      S_WR_MUL: state_d = S_WR_UPD;
      S_WR_UPD: state_d = S_IDLE;
      S_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == som_pkg::CNT_W'(som_pkg::NODE_COUNT - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) state_d = cmd_q.last ? S_HOLD : S_IDLE;
      end
      S_HOLD: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cnt_q      <= '0;
      clr_q      <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      norm_vld_q <= '0;
      out_vld_q  <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      s1_vld_q <= (state_q == S_SWEEP);
      s2_vld_q <= s1_vld_q;
      if (wr_commit) norm_vld_q[cmd_q.node] <= 1'b1;
      if (load_out) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      if (q_pop_o) found_q <= 1'b0;
      else if (s2_vld_q && cmd_q.last && in_map && (!found_q || acc_new < best_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  // Memory addressing
  assign rd_node = (state_q == S_SWEEP) ? cnt_q[som_pkg::NODE_W-1:0] : cmd_q.node;
  assign w_raddr = som_pkg::WADDR_W'(rd_node) * som_pkg::WADDR_W'(som_pkg::MAX_DIMS) +
                   som_pkg::WADDR_W'(cmd_q.dim);
  assign w_waddr = som_pkg::WADDR_W'(cmd_q.node) * som_pkg::WADDR_W'(som_pkg::MAX_DIMS) +
                   som_pkg::WADDR_W'(cmd_q.dim);

  // Weight memory; zeroed word by word after reset
  always_ff @(posedge clk_i) begin
    if (wr_commit) wmem[w_waddr] <= cmd_q.sample;
    else if (state_q == S_CLEAR) wmem[clr_q] <= '0;
    w_rdata_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_commit) norm_mem[cmd_q.node] <= norm_new;
    norm_rdata_q <= norm_mem[rd_node];
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) acc_mem[s2_node_q] <= acc_new;
    acc_rdata_q <= acc_mem[cnt_q[som_pkg::NODE_W-1:0]];
  end

  // Stage one: pick the base value, multiply weight by sample
  always_comb begin
    if (cmd_q.seed) begin
      s1_base = norm_vld_q[s1_node_q] ? $signed({{(som_pkg::ACC_W - som_pkg::NORM_W){1'b0}},
                                                  norm_rdata_q})
                                      : '0;
    end else begin
      s1_base = acc_rdata_q;
    end
  end

  // Stage two: accumulate, and track the minimum on the closing entry
  always_comb begin
    term    = cmd_q.apply ? (som_pkg::ACC_W'(vv_q) - (som_pkg::ACC_W'(s2_prod_q) <<< 1)) : '0;
    acc_new = s2_base_q + term;
    s2_x    = som_pkg::COORD_W'(s2_node_q % som_pkg::MAX_MAP_X);
    s2_y    = som_pkg::COORD_W'(s2_node_q / som_pkg::MAX_MAP_X);
    in_map  = (som_pkg::SIZE_W'(s2_x) < cfg_i.map_w) && (som_pkg::SIZE_W'(s2_y) < cfg_i.map_h);
  end

  // Norm update for a codebook write
  assign ww_prod  = w_rdata_q * w_rdata_q;
  assign norm_new = nbase_q + som_pkg::NORM_W'($unsigned(vv_q)) - som_pkg::NORM_W'(oo_q);

  // Result saturation
  always_comb begin
    if (best_q < 0) best_sat = '0;
    else if (best_q > som_pkg::DIST_MAX) best_sat = '1;
    else best_sat = best_q[som_pkg::DIST_W-1:0];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
      vv_q  <= q_data_i.sample * q_data_i.sample;
    end
    s1_node_q <= cnt_q[som_pkg::NODE_W-1:0];
    s2_node_q <= s1_node_q;
    s2_base_q <= s1_base;
    s2_prod_q <= w_rdata_q * cmd_q.sample;
    if (state_q == S_WR_MUL) begin
      oo_q    <= $unsigned(ww_prod);
      nbase_q <= norm_vld_q[cmd_q.node] ? norm_rdata_q : '0;
    end
    if (s2_vld_q && cmd_q.last && in_map && (!found_q || acc_new < best_q)) begin
      best_q <= acc_new;
      bx_q   <= s2_x;
      by_q   <= s2_y;
    end
    if (load_out) begin
      out_q.best_x           <= bx_q;
      out_q.best_y           <= by_q;
      out_q.best_sq_distance <= best_sat;
    end
  end

endmodule

// ===== rtl/som_sparse_best_matching_unit.sv =====
// Top level: configuration registers, front end, command queue and back end.
//
//   Port group    Handshake             Transfer
//   in            in_valid_i/in_ready_o  one codebook write or sparse entry
//   out           out_valid_o/out_ready_i one best matching node per vector
//   config        psel/penable/pready    one register write or read
//
// A queued sparse entry sweeps all 256 nodes through one weight memory port, one node a cycle.
// A codebook write steps through read, multiply and update; entries that change nothing are not queued.
// A two-entry queue lets the front keep accepting while the back is busy.
// After reset the back end zeroes the weight memory, one word a cycle.
module som_sparse_best_matching_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  som_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output som_pkg::out_item_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [som_pkg::PADDR_W-1:0]   paddr,
  input  logic [som_pkg::PDATA_W-1:0]   pwdata,
  output logic [som_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [som_pkg::SIZE_W-1:0]    map_width_q, map_height_q;
  logic [som_pkg::DIMS_W-1:0]    dims_q;
  logic [som_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  som_pkg::cfg_t                 cfg;
  som_pkg::front_sts_t           f_sts;
  som_pkg::queue_sts_t           q_sts;
  som_pkg::cmd_t                 push_cmd, head_cmd;
  logic                          q_push, q_pop, q_valid;

  assign pready  = 1'b1;
  assign reg_idx = paddr[som_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= som_pkg::SIZE_W'(som_pkg::MAX_MAP_X);
      map_height_q <= som_pkg::SIZE_W'(som_pkg::MAX_MAP_Y);
      dims_q       <= som_pkg::DIMS_W'(som_pkg::MAX_DIMS);
    end else if (cfg_wr) begin
      case (reg_idx)
        som_pkg::REG_MAP_WIDTH:   map_width_q  <= pwdata[som_pkg::SIZE_W-1:0];
        som_pkg::REG_MAP_HEIGHT:  map_height_q <= pwdata[som_pkg::SIZE_W-1:0];
        som_pkg::REG_DIMS_IN_USE: dims_q       <= pwdata[som_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      som_pkg::REG_MAP_WIDTH:   prdata = som_pkg::PDATA_W'(map_width_q);
      som_pkg::REG_MAP_HEIGHT:  prdata = som_pkg::PDATA_W'(map_height_q);
      som_pkg::REG_DIMS_IN_USE: prdata = som_pkg::PDATA_W'(dims_q);
      default:                  prdata = '0;
    endcase
  end

  // Effective sizes
  assign cfg.map_w = som_pkg::clamp_size(map_width_q, som_pkg::MAX_MAP_X);
  assign cfg.map_h = som_pkg::clamp_size(map_height_q, som_pkg::MAX_MAP_Y);
  assign cfg.dims  = som_pkg::clamp_dims(dims_q);

  som_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .q_full_i   (q_sts.full),
    .q_push_o   (q_push),
    .q_data_o   (push_cmd),
    .sts_o      (f_sts)
  );

  som_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_cmd),
    .sts_o   (q_sts)
  );

  som_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (head_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // A full queue must hold off the input side
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_sts.count == som_pkg::QCNT_W'(som_pkg::QUEUE_DEPTH)) |-> !in_ready_o)
    else $error("input accepted with queue full");

  // A closing entry ends the open vector
  a_close_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.req_type == som_pkg::REQ_ENTRY) &&
     in_data_i.last) |=> !f_sts.vec_open)
    else $error("vector still open after closing entry");

  // A non-closing entry leaves the vector open
  a_open_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.req_type == som_pkg::REQ_ENTRY) &&
     !in_data_i.last) |=> f_sts.vec_open)
    else $error("vector not open after entry");
`endif

endmodule
